// File: design/mi3_pkg.sv
// Shared constants for the 3x3 matrix inverse: element count, cofactor product map, register map.
`default_nettype none
package mi3_pkg;

    localparam int NUM_ELEM   = 9;
    localparam int NUM_PROD   = 18;
    localparam int THR_WIDTH  = 31;
    localparam logic [THR_WIDTH-1:0] THR_RESET = 31'd1;

    // register index of the singular threshold
    localparam logic REG_SINGULAR_THRESHOLD = 1'b0;

    // cofactor e = PROD_A[2e]*PROD_B[2e] - PROD_A[2e+1]*PROD_B[2e+1], indices r*3+c
    localparam int PROD_A [NUM_PROD] = '{4, 7, 2, 1, 1, 2, 5, 3, 0, 2, 3, 0, 3, 6, 6, 0, 0, 3};
    localparam int PROD_B [NUM_PROD] = '{8, 5, 7, 8, 5, 4, 6, 8, 8, 6, 2, 5, 7, 4, 1, 7, 4, 1};

endpackage
`default_nettype wire

// File: design/mi3_front.sv
// Front end: cofactors, determinant, singularity check, push into the queue.
`default_nettype none
module mi3_front #(
    parameter int ELEMENT_WIDTH = 32,
    parameter int FRACTION_BITS = 16,
    parameter int PAYLOAD_WIDTH = 1
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [ELEMENT_WIDTH-1:0] in_elem [mi3_pkg::NUM_ELEM],
    input  wire logic [mi3_pkg::THR_WIDTH-1:0] threshold,
    output logic                               push_valid,
    input  wire logic                          push_room,
    output logic [PAYLOAD_WIDTH-1:0]           push_data
);

    localparam int W    = ELEMENT_WIDTH;
    localparam int PW   = 2 * W;
    localparam int CW   = 2 * W + 1;
    localparam int DETW = 3 * W + 3;
    localparam int DMW  = (DETW > 2 * FRACTION_BITS + 1) ? DETW - 2 * FRACTION_BITS : 1;
    localparam int CMPT = (DMW > mi3_pkg::THR_WIDTH) ? DMW : mi3_pkg::THR_WIDTH;
    localparam int NE   = mi3_pkg::NUM_ELEM;

    logic                vld_reg [1:6];
    logic                adv;

    logic signed [PW-1:0]   prod_reg [mi3_pkg::NUM_PROD];
    logic signed [W-1:0]    row0_1_reg [3];
    logic signed [W-1:0]    row0_2_reg [3];
    logic signed [CW-1:0]   cof2_reg [NE];
    logic signed [CW-1:0]   cof3_reg [NE];
    logic signed [CW-1:0]   cof4_reg [NE];
    logic signed [CW-1:0]   cof5_reg [NE];
    logic signed [CW:0]     plo_reg [3];
    logic signed [CW:0]     phi_reg [3];
    logic signed [DETW-1:0] term_reg [3];
    logic signed [DETW-1:0] det_reg;
    logic [DMW-1:0]         dmag_reg;
    logic                   dneg_reg;
    logic [PW-1:0]          cmag_reg [NE];
    logic                   cneg_reg [NE];

    logic [DETW-1:0]        dabs;
    logic [CW-1:0]          cabs [NE];
    logic                   singular;

    assign adv      = !vld_reg[6] || push_room;
    assign in_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 1; s <= 6; s++) begin
                vld_reg[s] <= 1'b0;
            end
        end else if (adv) begin
            vld_reg[1] <= in_valid;
            for (int s = 2; s <= 6; s++) begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    always_comb begin
        dabs = det_reg[DETW-1] ? DETW'(-det_reg) : DETW'(det_reg);
        for (int e = 0; e < NE; e++) begin
            cabs[e] = cof5_reg[e][CW-1] ? CW'(-cof5_reg[e]) : CW'(cof5_reg[e]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            // products of element pairs
            for (int p = 0; p < mi3_pkg::NUM_PROD; p++) begin
                prod_reg[p] <= PW'(in_elem[mi3_pkg::PROD_A[p]])
                             * PW'(in_elem[mi3_pkg::PROD_B[p]]);
            end
            for (int k = 0; k < 3; k++) begin
                row0_1_reg[k] <= in_elem[k];
                row0_2_reg[k] <= row0_1_reg[k];
            end
            // cofactors
            for (int e = 0; e < NE; e++) begin
                cof2_reg[e] <= {prod_reg[2*e][PW-1], prod_reg[2*e]}
                             - {prod_reg[2*e+1][PW-1], prod_reg[2*e+1]};
                cof3_reg[e] <= cof2_reg[e];
                cof4_reg[e] <= cof3_reg[e];
                cof5_reg[e] <= cof4_reg[e];
            end
            // split row-0 products into low and high halves of the cofactor
            for (int k = 0; k < 3; k++) begin
                plo_reg[k] <= (CW+1)'(row0_2_reg[k]) * (CW+1)'($signed({1'b0, cof2_reg[3*k][W-1:0]}));
                phi_reg[k] <= (CW+1)'(row0_2_reg[k]) * (CW+1)'($signed(cof2_reg[3*k][CW-1:W]));
                term_reg[k] <= (DETW'(phi_reg[k]) <<< W) + DETW'(plo_reg[k]);
            end
            det_reg <= term_reg[0] + term_reg[1] + term_reg[2];
            // magnitudes and signs
            dneg_reg <= det_reg[DETW-1];
            dmag_reg <= DMW'(dabs >> (2 * FRACTION_BITS));
            for (int e = 0; e < NE; e++) begin
                cneg_reg[e] <= cof5_reg[e][CW-1];
                cmag_reg[e] <= cabs[e][PW-1:0];
            end
        end
    end

    assign singular = (dmag_reg == '0) || (CMPT'(dmag_reg) < CMPT'(threshold));

    always_comb begin
        push_data = '0;
        for (int e = 0; e < NE; e++) begin
            push_data[e*PW +: PW] = cmag_reg[e];
            push_data[NE*PW + e]  = cneg_reg[e];
        end
        push_data[NE*PW + NE +: DMW] = dmag_reg;
        push_data[NE*PW + NE + DMW]  = dneg_reg;
        push_data[NE*PW + NE + DMW + 1] = singular;
    end

    assign push_valid = vld_reg[6];

endmodule
`default_nettype wire

// File: design/mi3_fifo.sv
// Two-entry queue between front end and divider back end.
`default_nettype none
module mi3_fifo #(
    parameter int WIDTH = 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  room,
    output logic                  rd_valid,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             do_wr, do_rd;

    assign room     = count_reg != 2'd2;
    assign rd_valid = count_reg != 2'd0;
    assign do_wr    = wr_en && room;
    assign do_rd    = rd_en && rd_valid;
    assign rd_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (do_wr) wr_ptr_reg <= !wr_ptr_reg;
            if (do_rd) rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + 2'(do_wr) - 2'(do_rd);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule
`default_nettype wire

// File: design/mi3_back.sv
// Back end: nine bit-per-stage restoring dividers, sign and saturation, output register.
`default_nettype none
module mi3_back #(
    parameter int ELEMENT_WIDTH = 32,
    parameter int FRACTION_BITS = 16,
    parameter int PAYLOAD_WIDTH = 1
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     pop_valid,
    output logic                          pop_en,
    input  wire logic [PAYLOAD_WIDTH-1:0] pop_data,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic signed [ELEMENT_WIDTH-1:0] out_elem [mi3_pkg::NUM_ELEM],
    output logic                          out_invertible
);

    localparam int W    = ELEMENT_WIDTH;
    localparam int PW   = 2 * W;
    localparam int DETW = 3 * W + 3;
    localparam int DMW  = (DETW > 2 * FRACTION_BITS + 1) ? DETW - 2 * FRACTION_BITS : 1;
    localparam int CMPW = (W > DMW) ? W : DMW;
    localparam int RW   = CMPW + 1;
    localparam int NE   = mi3_pkg::NUM_ELEM;
    localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MAX_NEG = {1'b1, {(W-1){1'b0}}};

    logic             vld_reg  [0:W];
    logic [RW-1:0]    rem_reg  [0:W][NE];
    logic [W-1:0]     lo_reg   [0:W][NE];
    logic [W-1:0]     quo_reg  [0:W][NE];
    logic             ovf_reg  [0:W][NE];
    logic             neg_reg  [0:W][NE];
    logic [DMW-1:0]   dmag_reg [0:W];
    logic             sing_reg [0:W];
    logic             ovld_reg;
    logic [W-1:0]     res_reg  [NE];
    logic             inv_reg;

    logic             adv;
    logic [RW-1:0]    trial    [1:W][NE];
    logic             take     [1:W][NE];
    logic [PW-1:0]    in_cmag  [NE];
    logic [DMW-1:0]   in_dmag;
    logic             in_dneg;
    logic             big      [NE];
    logic [W-1:0]     res_next [NE];

    assign adv    = !ovld_reg || out_ready;
    assign pop_en = adv;

    always_comb begin
        for (int e = 0; e < NE; e++) begin
            in_cmag[e] = pop_data[e*PW +: PW];
        end
        in_dmag = pop_data[NE*PW + NE +: DMW];
        in_dneg = pop_data[NE*PW + NE + DMW];
    end

    // one quotient bit per stage
    always_comb begin
        for (int s = 1; s <= W; s++) begin
            for (int e = 0; e < NE; e++) begin
                trial[s][e] = {rem_reg[s-1][e][RW-2:0], lo_reg[s-1][e][W-1]};
                take[s][e]  = trial[s][e] >= RW'(dmag_reg[s-1]);
            end
        end
    end

    always_comb begin
        for (int e = 0; e < NE; e++) begin
            big[e] = ovf_reg[W][e] || quo_reg[W][e][W-1];
            if (sing_reg[W]) begin
                res_next[e] = '0;
            end else if (!neg_reg[W][e]) begin
                res_next[e] = big[e] ? MAX_POS : quo_reg[W][e];
            end else if (ovf_reg[W][e] || (quo_reg[W][e][W-1] && quo_reg[W][e][W-2:0] != '0)) begin
                res_next[e] = MAX_NEG;
            end else begin
                res_next[e] = W'(-quo_reg[W][e]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s <= W; s++) begin
                vld_reg[s] <= 1'b0;
            end
            ovld_reg <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= pop_valid;
            for (int s = 1; s <= W; s++) begin
                vld_reg[s] <= vld_reg[s-1];
            end
            ovld_reg <= vld_reg[W];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            // load: upper half of the dividend seeds the remainder
            dmag_reg[0] <= in_dmag;
            sing_reg[0] <= pop_data[NE*PW + NE + DMW + 1];
            for (int e = 0; e < NE; e++) begin
                rem_reg[0][e] <= RW'(in_cmag[e][PW-1:W]);
                lo_reg[0][e]  <= in_cmag[e][W-1:0];
                quo_reg[0][e] <= '0;
                ovf_reg[0][e] <= CMPW'(in_cmag[e][PW-1:W]) >= CMPW'(in_dmag);
                neg_reg[0][e] <= pop_data[NE*PW + e] != in_dneg;
            end
            for (int s = 1; s <= W; s++) begin
                dmag_reg[s] <= dmag_reg[s-1];
                sing_reg[s] <= sing_reg[s-1];
                for (int e = 0; e < NE; e++) begin
                    rem_reg[s][e] <= take[s][e] ? RW'(trial[s][e] - RW'(dmag_reg[s-1]))
                                                : trial[s][e];
                    lo_reg[s][e]  <= {lo_reg[s-1][e][W-2:0], 1'b0};
                    quo_reg[s][e] <= {quo_reg[s-1][e][W-2:0], take[s][e]};
                    ovf_reg[s][e] <= ovf_reg[s-1][e];
                    neg_reg[s][e] <= neg_reg[s-1][e];
                end
            end
            for (int e = 0; e < NE; e++) begin
                res_reg[e] <= res_next[e];
            end
            inv_reg <= !sing_reg[W];
        end
    end

    assign out_valid      = ovld_reg;
    assign out_invertible = inv_reg;
    always_comb begin
        for (int e = 0; e < NE; e++) begin
            out_elem[e] = $signed(res_reg[e]);
        end
    end

endmodule
`default_nettype wire

// File: design/matrix_inverse_3x3.sv
// Top level of the 3x3 fixed-point matrix inverse with APB threshold register.
// Path from input transfer to result, in registers:
//   six front stages (products, cofactors, determinant), one queue slot,
//   one load stage, one stage per quotient bit, one saturation/output stage.
// Throughput: one matrix per cycle unless m_ready stalls the output; the nine dividers retire one bit per stage.
// Reset (aresetn low, synchronous): pipeline and queue empty, threshold back to 1.
`default_nettype none
module matrix_inverse_3x3 #(
    parameter int ELEMENT_WIDTH = 32,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // input matrix
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire logic signed [ELEMENT_WIDTH-1:0] s_in_r0c0,
    input  wire logic signed [ELEMENT_WIDTH-1:0] s_in_r0c1,
    input  wire logic signed [ELEMENT_WIDTH-1:0] s_in_r0c2,
    input  wire logic signed [ELEMENT_WIDTH-1:0] s_in_r1c0,
    input  wire logic signed [ELEMENT_WIDTH-1:0] s_in_r1c1,
    input  wire logic signed [ELEMENT_WIDTH-1:0] s_in_r1c2,
    input  wire logic signed [ELEMENT_WIDTH-1:0] s_in_r2c0,
    input  wire logic signed [ELEMENT_WIDTH-1:0] s_in_r2c1,
    input  wire logic signed [ELEMENT_WIDTH-1:0] s_in_r2c2,
    // inverse
    output logic m_valid,
    input  wire logic m_ready,
    output logic signed [ELEMENT_WIDTH-1:0] m_out_r0c0,
    output logic signed [ELEMENT_WIDTH-1:0] m_out_r0c1,
    output logic signed [ELEMENT_WIDTH-1:0] m_out_r0c2,
    output logic signed [ELEMENT_WIDTH-1:0] m_out_r1c0,
    output logic signed [ELEMENT_WIDTH-1:0] m_out_r1c1,
    output logic signed [ELEMENT_WIDTH-1:0] m_out_r1c2,
    output logic signed [ELEMENT_WIDTH-1:0] m_out_r2c0,
    output logic signed [ELEMENT_WIDTH-1:0] m_out_r2c1,
    output logic signed [ELEMENT_WIDTH-1:0] m_out_r2c2,
    output logic m_invertible
);

    localparam int W    = ELEMENT_WIDTH;
    localparam int NE   = mi3_pkg::NUM_ELEM;
    localparam int DETW = 3 * W + 3;
    localparam int DMW  = (DETW > 2 * FRACTION_BITS + 1) ? DETW - 2 * FRACTION_BITS : 1;
    // queue entry: nine cofactor magnitudes and signs, |det|, det sign, singular flag
    localparam int PLW  = NE * 2 * W + NE + DMW + 2;

    logic [mi3_pkg::THR_WIDTH-1:0] thr_reg;
    logic                          reg_hit;

    logic signed [W-1:0] in_elem  [NE];
    logic signed [W-1:0] out_elem [NE];

    logic             push_valid, push_room;
    logic [PLW-1:0]   push_data;
    logic             pop_valid, pop_en;
    logic [PLW-1:0]   pop_data;

    // APB: zero-wait writes, word address selects the register
    assign pready  = 1'b1;
    assign reg_hit = paddr[2] == mi3_pkg::REG_SINGULAR_THRESHOLD;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= mi3_pkg::THR_RESET;
        end else if (psel && penable && pwrite && reg_hit) begin
            // drop bit 31; the threshold is 31 bits
            thr_reg <= pwdata[mi3_pkg::THR_WIDTH-1:0];
        end
    end

    assign prdata = reg_hit ? {1'b0, thr_reg} : 32'd0;

    // gather elements in row-major order
    assign in_elem[0] = s_in_r0c0;
    assign in_elem[1] = s_in_r0c1;
    assign in_elem[2] = s_in_r0c2;
    assign in_elem[3] = s_in_r1c0;
    assign in_elem[4] = s_in_r1c1;
    assign in_elem[5] = s_in_r1c2;
    assign in_elem[6] = s_in_r2c0;
    assign in_elem[7] = s_in_r2c1;
    assign in_elem[8] = s_in_r2c2;

    // front: cofactors, determinant, singular check
    mi3_front #(
        .ELEMENT_WIDTH (ELEMENT_WIDTH),
        .FRACTION_BITS (FRACTION_BITS),
        .PAYLOAD_WIDTH (PLW)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_elem    (in_elem),
        .threshold  (thr_reg),
        .push_valid (push_valid),
        .push_room  (push_room),
        .push_data  (push_data)
    );

    // queue: lets the front keep accepting while the output stalls briefly
    mi3_fifo #(
        .WIDTH (PLW)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (push_valid),
        .wr_data  (push_data),
        .room     (push_room),
        .rd_valid (pop_valid),
        .rd_en    (pop_en),
        .rd_data  (pop_data)
    );

    // back: divide each cofactor by |det|, apply sign, saturate
    mi3_back #(
        .ELEMENT_WIDTH (ELEMENT_WIDTH),
        .FRACTION_BITS (FRACTION_BITS),
        .PAYLOAD_WIDTH (PLW)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .pop_valid      (pop_valid),
        .pop_en         (pop_en),
        .pop_data       (pop_data),
        .out_valid      (m_valid),
        .out_ready      (m_ready),
        .out_elem       (out_elem),
        .out_invertible (m_invertible)
    );

    assign m_out_r0c0 = out_elem[0];
    assign m_out_r0c1 = out_elem[1];
    assign m_out_r0c2 = out_elem[2];
    assign m_out_r1c0 = out_elem[3];
    assign m_out_r1c1 = out_elem[4];
    assign m_out_r1c2 = out_elem[5];
    assign m_out_r2c0 = out_elem[6];
    assign m_out_r2c1 = out_elem[7];
    assign m_out_r2c2 = out_elem[8];

endmodule
`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for the 3x3 fixed-point matrix inverse.
`timescale 1ns / 1ps
`default_nettype none
module tb;

    localparam int EW      = 32;
    localparam int FB      = 16;
    localparam int LATENCY = EW + 9;

    typedef logic signed [EW-1:0] elem_t;
    typedef struct packed {
        elem_t [8:0] e;
        logic        inv;
    } inverse_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic s_valid = 1'b0;
    logic s_ready;
    elem_t s_elem [9];
    logic m_valid;
    logic m_ready = 1'b0;
    elem_t m_elem [9];
    logic m_invertible;

    logic [mi3_pkg::THR_WIDTH-1:0] threshold;
    inverse_t inverse_q [$];
    int  errors = 0;
    bit  hold_off = 1'b0;
    bit  burst_out = 1'b0;

    initial for (int i = 0; i < 9; i++) s_elem[i] = '0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    matrix_inverse_3x3 #(.ELEMENT_WIDTH(EW), .FRACTION_BITS(FB)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_in_r0c0(s_elem[0]), .s_in_r0c1(s_elem[1]), .s_in_r0c2(s_elem[2]),
        .s_in_r1c0(s_elem[3]), .s_in_r1c1(s_elem[4]), .s_in_r1c2(s_elem[5]),
        .s_in_r2c0(s_elem[6]), .s_in_r2c1(s_elem[7]), .s_in_r2c2(s_elem[8]),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_out_r0c0(m_elem[0]), .m_out_r0c1(m_elem[1]), .m_out_r0c2(m_elem[2]),
        .m_out_r1c0(m_elem[3]), .m_out_r1c1(m_elem[4]), .m_out_r1c2(m_elem[5]),
        .m_out_r2c0(m_elem[6]), .m_out_r2c1(m_elem[7]), .m_out_r2c2(m_elem[8]),
        .m_invertible(m_invertible)
    );

    // Exact adjugate inverse: cofactors and determinant held at full width,
    // determinant truncated toward zero, one quotient per element, saturated.
    function automatic inverse_t invert(input elem_t a [9]);
        logic signed [127:0] m [9];
        logic signed [127:0] cof [9];
        logic signed [127:0] det, dmag, cmag, quo;
        logic dneg;
        inverse_t r;
        for (int i = 0; i < 9; i++) m[i] = a[i];
        for (int e = 0; e < 9; e++)
            cof[e] = m[mi3_pkg::PROD_A[2*e]] * m[mi3_pkg::PROD_B[2*e]]
                   - m[mi3_pkg::PROD_A[2*e+1]] * m[mi3_pkg::PROD_B[2*e+1]];
        det  = m[0] * cof[0] + m[1] * cof[3] + m[2] * cof[6];
        dneg = det < 0;
        dmag = (dneg ? -det : det) >>> (2 * FB);
        r = '0;
        if (dmag == 0 || dmag < threshold) return r;
        r.inv = 1'b1;
        for (int e = 0; e < 9; e++) begin
            cmag = cof[e] < 0 ? -cof[e] : cof[e];
            quo  = cmag / dmag;
            if ((cof[e] < 0) == dneg)
                r.e[e] = quo > 128'sh7FFF_FFFF ? 32'sh7FFF_FFFF : quo[EW-1:0];
            else
                r.e[e] = quo > 128'sh8000_0000 ? 32'sh8000_0000 : -quo[EW-1:0];
        end
        return r;
    endfunction

    // Short gaps mostly, an occasional long one.
    function automatic int gap_len();
        if ($urandom_range(0, 3) == 0) return 0;
        return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
    endfunction

    // Transfer one matrix; queue its inverse at the accepting edge.
    // Enter and leave at a falling edge; valid stays high into the next call.
    task automatic send_matrix(input elem_t a [9], input bit idle);
        int g;
        g = idle ? gap_len() : 0;
        if (g != 0) begin
            s_valid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_elem  = a;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        inverse_q.push_back(invert(a));
        @(negedge aclk);
    endtask

    // Drop valid after the last matrix of a sequence.
    task automatic end_input();
        s_valid <= 1'b0;
    endtask

    task automatic write_threshold(input logic [31:0] v);
        @(negedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {mi3_pkg::REG_SINGULAR_THRESHOLD, 2'b00}; pwdata <= v;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        threshold = v[mi3_pkg::THR_WIDTH-1:0];
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic drain();
        while (inverse_q.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic elem_t rand_elem();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            2: return elem_t'($signed($urandom_range(0, 8 << FB)) - (4 << FB));
            3: return elem_t'($signed($urandom_range(0, 1 << FB)) - (1 << (FB - 1)));
            default: return elem_t'($signed($urandom_range(0, 64)) - 32) <<< FB;
        endcase
    endfunction

    // Receiver: random stalls, a long hold-off while the pressure test runs, none while streaming.
    initial begin
        int g;
        forever begin
            @(negedge aclk);
            if (!hold_off && !burst_out) begin
                g = gap_len();
                if (g != 0) begin
                    m_ready <= 1'b0;
                    repeat (g) @(negedge aclk);
                end
            end
            m_ready <= !hold_off;
        end
    end

    // Compare every transfer on the result channel with the oldest inverse.
    always @(posedge aclk) begin
        inverse_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (inverse_q.size() == 0) begin
                $display("%0t: unexpected result", $time);
                errors++;
            end else begin
                exp_r = inverse_q.pop_front();
                for (int e = 0; e < 9; e++)
                    if (m_elem[e] !== exp_r.e[e]) begin
                        $display("%0t: element %0d expected %h actual %h",
                                 $time, e, exp_r.e[e], m_elem[e]);
                        errors++;
                    end
                if (m_invertible !== exp_r.inv) begin
                    $display("%0t: invertible expected %b actual %b",
                             $time, exp_r.inv, m_invertible);
                    errors++;
                end
            end
        end
    end

    task automatic test_directed();
        elem_t a [9];
        localparam elem_t ONE = 1 <<< FB;
        // identity, scaled identity, negated identity
        a = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};            send_matrix(a, 1);
        a = '{2*ONE, 0, 0, 0, 4*ONE, 0, 0, 0, -8*ONE};     send_matrix(a, 1);
        a = '{-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE};         send_matrix(a, 1);
        // general matrix
        a = '{2*ONE, ONE, 0, ONE, 3*ONE, ONE, 0, ONE, 4*ONE}; send_matrix(a, 1);
        // all zero, rank one: singular
        a = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                  send_matrix(a, 1);
        a = '{ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE}; send_matrix(a, 1);
        // tiny determinant near the threshold
        a = '{1 <<< 8, 0, 0, 0, 1 <<< 8, 0, 0, 0, ONE};     send_matrix(a, 1);
        a = '{1 <<< 8, 0, 0, 0, 1 <<< 7, 0, 0, 0, ONE};     send_matrix(a, 1);
        // small diagonal with either sign: inverse elements of magnitude 16.0, below saturation
        a = '{1 <<< 12, 0, 0, 0, 1 <<< 12, 0, 0, 0, 1 <<< 12}; send_matrix(a, 1);
        a = '{-(1 <<< 12), 0, 0, 0, 1 <<< 12, 0, 0, 0, 1 <<< 12}; send_matrix(a, 1);
        // field extremes
        a = '{32'sh7FFF_FFFF, 0, 0, 0, 32'sh7FFF_FFFF, 0, 0, 0, 32'sh7FFF_FFFF};
        send_matrix(a, 1);
        a = '{32'sh8000_0000, 0, 0, 0, 32'sh8000_0000, 0, 0, 0, 32'sh8000_0000};
        send_matrix(a, 1);
        for (int i = 0; i < 9; i++) a[i] = 32'sh8000_0000; send_matrix(a, 1);
        for (int i = 0; i < 9; i++) a[i] = 32'sh7FFF_FFFF; send_matrix(a, 1);
        for (int i = 0; i < 9; i++) a[i] = -1;             send_matrix(a, 1);
        a = '{32'sh7FFF_FFFF, 32'sh8000_0000, 1, -1, 32'sh7FFF_FFFF, 3,
              32'sh8000_0000, 5, 32'sh7FFF_FFFF};          send_matrix(a, 1);
        end_input();
        drain();
    endtask

    task automatic test_random(input int count);
        elem_t a [9];
        for (int n = 0; n < count; n++) begin
            for (int i = 0; i < 9; i++) a[i] = rand_elem();
            send_matrix(a, 1);
        end
        end_input();
        drain();
    endtask

    // Zero threshold: a zero determinant must still count as singular.
    task automatic test_zero_threshold();
        elem_t a [9];
        write_threshold(32'd0);
        for (int i = 0; i < 9; i++) a[i] = 0; send_matrix(a, 1);
        a = '{1, 0, 0, 0, 1, 0, 0, 0, 1};     send_matrix(a, 1);
        a = '{1 <<< FB, 0, 0, 0, 1, 0, 0, 0, 1}; send_matrix(a, 1);
        test_random(80);
    endtask

    // Hold the result side off long enough to back the pipeline up.
    task automatic test_backpressure();
        elem_t a [9];
        hold_off = 1'b1;
        fork
            begin
                repeat (3 * LATENCY) @(posedge aclk);
                hold_off = 1'b0;
            end
            begin
                for (int n = 0; n < 2 * LATENCY; n++) begin
                    for (int i = 0; i < 9; i++) a[i] = rand_elem();
                    send_matrix(a, 0);
                end
                end_input();
            end
        join
        drain();
    endtask

    // Full rate on both sides.
    task automatic test_streaming();
        elem_t a [9];
        burst_out = 1'b1;
        for (int n = 0; n < 100; n++) begin
            for (int i = 0; i < 9; i++) a[i] = rand_elem();
            send_matrix(a, 0);
        end
        end_input();
        drain();
        burst_out = 1'b0;
    endtask

    initial begin
        threshold = mi3_pkg::THR_RESET;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_random(200);
        test_zero_threshold();
        write_threshold(32'h7FFF_FFFF);   // all 31 threshold bits high, top bit clear
        test_random(60);
        write_threshold(32'hFFFF_FFFF);
        test_random(40);
        write_threshold(32'h0001_0000);
        test_random(120);
        test_backpressure();
        write_threshold(32'd1);
        test_streaming();
        test_random(150);

        if (errors == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
`default_nettype wire

// File: matrix_inverse_3x3.f
design/mi3_pkg.sv
design/mi3_front.sv
design/mi3_fifo.sv
design/mi3_back.sv
design/matrix_inverse_3x3.sv
tb/tb.sv
